### hw/rtl/cau_pkg.sv
// shared types, constants and arithmetic helpers for the complex arithmetic unit
package cau_pkg;

  localparam int W   = 32;          // word width of every operand and result part
  localparam int F   = 16;          // fraction bits
  localparam int PW  = 2 * W;       // full product width
  localparam int SW  = 2 * W + 1;   // sum of two products
  localparam int XW  = 2 * W + 2;   // headroom width for rounding and saturation
  localparam int QB  = W + 1;       // quotient bits kept by the divider
  localparam int NW  = PW + F;      // scaled dividend magnitude width
  localparam int NST = QB + 4;      // pipeline stages: front 3, divide QB, round 1

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [QB:0]  QMIN = {{(QB-W+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic          flag;
    logic [W-1:0]  val;
  } sat_t;

  // one part (re or im) of a division in flight
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [PW-1:0] rem;
    logic [QB-1:0] quo;
    logic [QB-1:0] num;
  } dpart_t;

  typedef struct packed {
    logic          is_div;
    logic [W-1:0]  re;
    logic [W-1:0]  im;
    status_e       status;
    logic [PW-1:0] den;
    dpart_t        dr;
    dpart_t        di;
  } item_t;

  typedef struct packed {
    logic [W-1:0]  re;
    logic [W-1:0]  im;
    status_e       status;
  } res_t;

  // clamp a wide signed value to the word range
  function automatic sat_t sat_word(input logic [XW-1:0] v);
    sat_t r;
    logic all1;
    logic all0;
    all1   = &v[XW-1:W-1];
    all0   = ~|v[XW-1:W-1];
    r.flag = !(all1 || all0);
    r.val  = r.flag ? (v[XW-1] ? WMIN : WMAX) : v[W-1:0];
    return r;
  endfunction

  // magnitude, scaling and early overflow test of a dividend
  function automatic dpart_t div_prep(input logic [SW-1:0] s, input logic [PW-1:0] den);
    dpart_t        r;
    logic [SW-1:0] m;
    logic [NW-1:0] n;
    r.neg = s[SW-1];
    m     = r.neg ? (SW'(0) - s) : s;
    n     = {m[PW-1:0], {F{1'b0}}};
    r.rem = PW'(n[NW-1:QB]);
    r.ovf = r.rem >= den;
    r.quo = '0;
    r.num = n[QB-1:0];
    return r;
  endfunction

  // one restoring division step
  function automatic dpart_t div_step(input dpart_t p, input logic [PW-1:0] den);
    dpart_t      r;
    logic [PW:0] t;
    logic [PW:0] d;
    logic        ge;
    t     = {p.rem, p.num[QB-1]};
    d     = t - {1'b0, den};
    ge    = t >= {1'b0, den};
    r     = p;
    r.rem = ge ? d[PW-1:0] : t[PW-1:0];
    r.quo = {p.quo[QB-2:0], ge};
    r.num = {p.num[QB-2:0], 1'b0};
    return r;
  endfunction

  // round half away from zero, apply sign, saturate
  function automatic sat_t div_final(input dpart_t p, input logic [PW-1:0] den);
    sat_t        r;
    logic        up;
    logic        big;
    logic [QB:0] q1;
    up     = p.rem >= (den - p.rem);
    q1     = {1'b0, p.quo} + (QB+1)'(up);
    big    = |q1[QB:W-1];
    r.flag = p.ovf || (big && !(p.neg && (q1 == QMIN)));
    if (r.flag) begin
      r.val = p.neg ? WMIN : WMAX;
    end else begin
      r.val = p.neg ? (W'(0) - q1[W-1:0]) : q1[W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/cau_front.sv
// front stages: products, sums, then rounding or divide setup
module cau_front import cau_pkg::*; (
  input  logic           clk_i,
  input  logic           en_i,
  input  mode_e          mode_i,
  input  logic [W-1:0]   a_re_i,
  input  logic [W-1:0]   a_im_i,
  input  logic [W-1:0]   b_re_i,
  input  logic [W-1:0]   b_im_i,
  output item_t          item_o
);

  typedef struct packed {
    mode_e         mode;
    logic [W-1:0]  a_re;
    logic [W-1:0]  a_im;
    logic          b_zero;
    logic [W:0]    add_re;
    logic [W:0]    add_im;
    logic [PW-1:0] p_rr;
    logic [PW-1:0] p_ii;
    logic [PW-1:0] p_ri;
    logic [PW-1:0] p_ir;
    logic [PW-1:0] p_bb;
  } s1_t;

  typedef struct packed {
    mode_e         mode;
    logic [W-1:0]  a_re;
    logic [W-1:0]  a_im;
    logic          b_zero;
    logic [W:0]    add_re;
    logic [W:0]    add_im;
    logic [SW-1:0] sum_re;
    logic [SW-1:0] sum_im;
    logic [PW-1:0] den;
  } s2_t;

  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  item_t it_d, it_q;

  logic signed [W-1:0]  ar, ai, br, bi;
  logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir, m_br, m_bi;
  logic [SW-1:0]        rr_x, ii_x, ri_x, ir_x;
  logic signed [XW-1:0] rnd_re, rnd_im;
  sat_t                 sr, si;

  // stage 1: four cross products, |b|^2 terms, add/sub
  always_comb begin
    ar   = $signed(a_re_i);
    ai   = $signed(a_im_i);
    br   = $signed(b_re_i);
    bi   = $signed(b_im_i);
    m_rr = ar * br;
    m_ii = ai * bi;
    m_ri = ar * bi;
    m_ir = ai * br;
    m_br = br * br;
    m_bi = bi * bi;
    s1_d.mode   = mode_i;
    s1_d.a_re   = a_re_i;
    s1_d.a_im   = a_im_i;
    s1_d.b_zero = (b_re_i == '0) && (b_im_i == '0);
    if (mode_i == MODE_SUB) begin
      s1_d.add_re = {a_re_i[W-1], a_re_i} - {b_re_i[W-1], b_re_i};
      s1_d.add_im = {a_im_i[W-1], a_im_i} - {b_im_i[W-1], b_im_i};
    end else begin
      s1_d.add_re = {a_re_i[W-1], a_re_i} + {b_re_i[W-1], b_re_i};
      s1_d.add_im = {a_im_i[W-1], a_im_i} + {b_im_i[W-1], b_im_i};
    end
    s1_d.p_rr = m_rr;
    s1_d.p_ii = m_ii;
    s1_d.p_ri = m_ri;
    s1_d.p_ir = m_ir;
    s1_d.p_bb = m_br + m_bi;
  end

  // stage 2: sums of products, picked by operation
  always_comb begin
    rr_x = {s1_q.p_rr[PW-1], s1_q.p_rr};
    ii_x = {s1_q.p_ii[PW-1], s1_q.p_ii};
    ri_x = {s1_q.p_ri[PW-1], s1_q.p_ri};
    ir_x = {s1_q.p_ir[PW-1], s1_q.p_ir};
    s2_d.mode   = s1_q.mode;
    s2_d.a_re   = s1_q.a_re;
    s2_d.a_im   = s1_q.a_im;
    s2_d.b_zero = s1_q.b_zero;
    s2_d.add_re = s1_q.add_re;
    s2_d.add_im = s1_q.add_im;
    s2_d.den    = s1_q.p_bb;
    if (s1_q.mode == MODE_DIV) begin
      s2_d.sum_re = rr_x + ii_x;
      s2_d.sum_im = ir_x - ri_x;
    end else begin
      s2_d.sum_re = rr_x - ii_x;
      s2_d.sum_im = ri_x + ir_x;
    end
  end

  // stage 3: finish add/sub/mul, set up divide
  always_comb begin
    it_d     = '0;
    it_d.den = s2_q.den;
    rnd_re   = XW'($signed(s2_q.sum_re)) + XW'(1 << (F - 1));
    rnd_im   = XW'($signed(s2_q.sum_im)) + XW'(1 << (F - 1));
    rnd_re   = rnd_re >>> F;
    rnd_im   = rnd_im >>> F;
    sr       = sat_word(XW'($signed(s2_q.add_re)));
    si       = sat_word(XW'($signed(s2_q.add_im)));
    case (s2_q.mode)
      MODE_ADD, MODE_SUB: begin
        sr = sat_word(XW'($signed(s2_q.add_re)));
        si = sat_word(XW'($signed(s2_q.add_im)));
      end
      MODE_MUL: begin
        sr = sat_word(rnd_re);
        si = sat_word(rnd_im);
      end
      MODE_DIV: begin
        sr.flag = 1'b0;
        si.flag = 1'b0;
        sr.val  = s2_q.a_re;
        si.val  = s2_q.a_im;
      end
      default: begin
        sr = '0;
        si = '0;
      end
    endcase
    it_d.re     = sr.val;
    it_d.im     = si.val;
    it_d.status = (sr.flag || si.flag) ? ST_SAT : ST_OK;
    if (s2_q.mode == MODE_DIV) begin
      if (s2_q.b_zero) begin
        it_d.status = ST_DIV0;
      end else begin
        it_d.is_div = 1'b1;
        it_d.dr     = div_prep(s2_q.sum_re, s2_q.den);
        it_d.di     = div_prep(s2_q.sum_im, s2_q.den);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      it_q <= it_d;
    end
  end

  assign item_o = it_q;

endmodule

### hw/rtl/cau_div_step.sv
// one registered restoring divide step for both parts
module cau_div_step import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  item_t item_i,
  output item_t item_o
);

  item_t it_d, it_q;

  always_comb begin
    it_d    = item_i;
    it_d.dr = div_step(item_i.dr, item_i.den);
    it_d.di = div_step(item_i.di, item_i.den);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it_q <= it_d;
    end
  end

  assign item_o = it_q;

endmodule

### hw/rtl/cau_round.sv
// last pipeline stage: quotient rounding, sign and saturation
module cau_round import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  item_t item_i,
  output res_t  res_o
);

  res_t res_d, res_q;
  sat_t qr, qi;

  always_comb begin
    qr = div_final(item_i.dr, item_i.den);
    qi = div_final(item_i.di, item_i.den);
    if (item_i.is_div) begin
      res_d.re     = qr.val;
      res_d.im     = qi.val;
      res_d.status = (qr.flag || qi.flag) ? ST_SAT : ST_OK;
    end else begin
      res_d.re     = item_i.re;
      res_d.im     = item_i.im;
      res_d.status = item_i.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/complex_arithmetic_unit.sv
// throughput: one word per cycle while the skid entry is empty;
// 3 front stages, 33 divide steps, 1 round stage
// every operation runs the full pipe so results leave in order
// an output register plus one skid entry let input continue while a result waits
// reset (async, active low) clears valid bits only; data registers are not reset
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // a_re, a_im, b_re, b_im (32 bits each)
  input  logic [1:0]   s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // res_re, res_im (32 bits each)
  output logic [1:0]   m_axis_tuser    // status
);

  // pipeline moves as a whole; only a full skid entry holds it
  logic            en;
  logic [NST-1:0]  v_q;
  item_t           stg [QB+1];
  res_t            pipe_res;

  logic            out_v_q, sk_v_q;
  res_t            out_q, sk_q;

  assign en            = !sk_v_q;
  assign s_axis_tready = en;

  cau_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_e'(s_axis_tuser)),
    .a_re_i (s_axis_tdata[W-1:0]),
    .a_im_i (s_axis_tdata[2*W-1:W]),
    .b_re_i (s_axis_tdata[3*W-1:2*W]),
    .b_im_i (s_axis_tdata[4*W-1:3*W]),
    .item_o (stg[0])
  );

  // one restoring step per stage, msb of the quotient window first
  for (genvar g = 0; g < QB; g++) begin : g_div
    cau_div_step u_step (
      .clk_i  (clk_i),
      .en_i   (en),
      .item_i (stg[g]),
      .item_o (stg[g+1])
    );
  end

  cau_round u_round (
    .clk_i  (clk_i),
    .en_i   (en),
    .item_i (stg[QB]),
    .res_o  (pipe_res)
  );

  // valid bits follow the data down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid};
    end
  end

  // output register and skid entry control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (m_axis_tready) begin
        sk_v_q <= 1'b0;
      end
    end else if (v_q[NST-1]) begin
      if (out_v_q && !m_axis_tready) begin
        sk_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (m_axis_tready) begin
        out_q <= sk_q;
      end
    end else if (v_q[NST-1]) begin
      if (out_v_q && !m_axis_tready) begin
        sk_q <= pipe_res;
      end else begin
        out_q <= pipe_res;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.im, out_q.re};
  assign m_axis_tuser  = out_q.status;

endmodule

### tb/tb_top.sv
// testbench for the complex arithmetic unit: random and directed words checked against a predictor
module tb_top;
  import cau_pkg::*;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    status_e     st;
  } cplx_res_t;

  // predicts results of accepted words and checks returned words in order
  class cplx_scoreboard;
    cplx_res_t pending[$];
    int        errors;

    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic sat);
      if (v > 128'sd2147483647) begin
        sat = 1'b1;
        return 32'h7fffffff;
      end
      if (v < -128'sd2147483648) begin
        sat = 1'b1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    // round to nearest, ties away from zero
    function automatic logic [31:0] quot(input logic signed [127:0] num,
                                         input logic [127:0] den, inout logic sat);
      logic [127:0] mag;
      logic [127:0] q;
      logic [127:0] r;
      logic signed [127:0] s;
      mag = num[127] ? -num : num;
      mag = mag << 16;
      q = mag / den;
      r = mag % den;
      if (r >= den - r) q = q + 1;
      s = num[127] ? -$signed(q) : $signed(q);
      return clamp(s, sat);
    endfunction

    function void note(input mode_e m, input logic [31:0] ar, input logic [31:0] ai,
                       input logic [31:0] br, input logic [31:0] bi);
      logic signed [127:0] xr;
      logic signed [127:0] xi;
      logic signed [127:0] yr;
      logic signed [127:0] yi;
      logic signed [127:0] pr;
      logic signed [127:0] pi;
      logic [127:0] den;
      logic sat;
      cplx_res_t e;
      xr = $signed(ar); xi = $signed(ai); yr = $signed(br); yi = $signed(bi);
      sat = 1'b0;
      e.st = ST_OK;
      case (m)
        MODE_ADD: begin
          e.re = clamp(xr + yr, sat);
          e.im = clamp(xi + yi, sat);
        end
        MODE_SUB: begin
          e.re = clamp(xr - yr, sat);
          e.im = clamp(xi - yi, sat);
        end
        MODE_MUL: begin
          // add half an lsb, then floor shift
          pr = (xr * yr - xi * yi + 128'sd32768) >>> 16;
          pi = (xr * yi + xi * yr + 128'sd32768) >>> 16;
          e.re = clamp(pr, sat);
          e.im = clamp(pi, sat);
        end
        default: begin
          if (br == 0 && bi == 0) begin
            e.re = ar;
            e.im = ai;
            e.st = ST_DIV0;
          end else begin
            den = yr * yr + yi * yi;
            e.re = quot(xr * yr + xi * yi, den, sat);
            e.im = quot(xi * yr - xr * yi, den, sat);
          end
        end
      endcase
      if (sat) e.st = ST_SAT;
      pending.push_back(e);
    endfunction

    task report_err(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(input logic [63:0] d, input logic [1:0] st);
      cplx_res_t e;
      if (pending.size() == 0) begin
        report_err("result word with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.re) report_err($sformatf("res_re %h want %h", d[31:0], e.re));
      if (d[63:32] !== e.im) report_err($sformatf("res_im %h want %h", d[63:32], e.im));
      if (st !== e.st) report_err($sformatf("status %0d want %0d", st, e.st));
    endtask
  endclass

  cplx_scoreboard sb;
  int             hold_cycles;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  complex_arithmetic_unit dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // send one word, holding it until accepted
  task automatic send_word(input mode_e m, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= {bi, br, ai, ar};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(m, ar, ai, br, bi);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // operand part biased toward edges and small magnitudes
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      5: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    logic [31:0] ext[4];
    int burst;
    sb = new();
    hold_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes of each operation, divide by zero, saturation
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    for (int m = 0; m < 4; m++) begin
      for (int k = 0; k < 4; k++) begin
        send_word(mode_e'(m), ext[k], ext[3 - k], ext[(k + 1) % 4], ext[(k + 2) % 4]);
      end
    end
    send_word(MODE_DIV, 32'h12345678, 32'h87654321, 32'h0, 32'h0);
    send_word(MODE_DIV, 32'h00010000, 32'h0, 32'h00000001, 32'h0);
    send_word(MODE_DIV, 32'h00008000, 32'h0, 32'h00010000, 32'h0);
    send_word(MODE_MUL, 32'h00008000, 32'h0, 32'h00000001, 32'h0);
    send_word(MODE_MUL, 32'hffff8000, 32'h0, 32'h00000001, 32'h0);

    // long receiver hold-off while the sender keeps offering words
    hold_cycles = 120;
    for (int i = 0; i < 60; i++) begin
      send_word(mode_e'($urandom_range(0, 3)), rand_part(), rand_part(),
                rand_part(), rand_part());
    end

    // sender pause until everything has drained
    idle_gap(1);
    while (sb.pending.size() != 0) @(negedge clk_i);

    // random bursts with random gaps
    for (int i = 0; i < 800; i += burst) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++) begin
        send_word(mode_e'($urandom_range(0, 3)), rand_part(), rand_part(),
                  rand_part(), rand_part());
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
